### sv/wcqs_pkg.sv
package wcqs_pkg;

  localparam int CLASS_COUNT = 5;
  localparam int QUEUE_DEPTH = 64;
  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
  localparam int MEM_DEPTH = CLASS_COUNT * QUEUE_DEPTH;
  localparam int ADDR_W = $clog2(MEM_DEPTH);
  localparam int TOTAL_W = $clog2(MEM_DEPTH + 1);
  localparam int CLS_W = 3;
  localparam int WEIGHT_W = 8;
  localparam int UNIT_W = 16;
  localparam int ACCOUNT_W = 31;
  localparam int OPS_W = 16;
  localparam int TIME_W = 32;
  localparam int WAIT_W = 9;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT5 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_UNIT = 3'd5;

  typedef enum logic {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    STAT_ENQ    = 2'd0,
    STAT_REJ    = 2'd1,
    STAT_SERVED = 2'd2,
    STAT_NONE   = 2'd3
  } status_t;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_t;

  typedef struct packed {
    op_t                  op;
    logic [CLS_W-1:0]     class_id;
    logic [ACCOUNT_W-1:0] account;
    logic [OPS_W-1:0]     op_count;
  } in_word_t;

  typedef struct packed {
    status_t              status;
    logic [ACCOUNT_W-1:0] served_account;
    logic [OPS_W-1:0]     served_ops;
    logic [CLS_W-1:0]     served_class;
    logic [TIME_W-1:0]    service_time;
    logic [WAIT_W-1:0]    waiting_total;
  } out_word_t;

  typedef struct packed {
    logic [ACCOUNT_W-1:0] account;
    logic [OPS_W-1:0]     op_count;
  } entry_t;

  typedef logic [CLASS_COUNT-1:0][WEIGHT_W-1:0] weight_arr_t;

  typedef struct packed {
    logic               enq_ok;
    logic               deq_ok;
    logic [CLS_W-1:0]   pick;
    logic [TOTAL_W-1:0] waiting;
    logic [TOTAL_W-1:0] waiting_nxt;
  } sched_t;

  function automatic logic [ADDR_W-1:0] slot_addr(input logic [CLS_W-1:0] idx,
                                                  input logic [PTR_W-1:0] ptr);
    slot_addr = ADDR_W'(ADDR_W'(idx) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(ptr));
  endfunction

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] ptr);
    ptr_inc = (ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(ptr + 1'b1);
  endfunction

endpackage

### sv/weighted_class_queue_scheduler.sv
// Weighted class queue scheduler with five first-in first-out class queues.
// An input word is taken at a rising edge where start is high and busy is low.
// An enqueue word stores its account and operation count at the tail of the
// queue named by class_id; a dequeue word serves the first class, from class 1
// to class 5, that has entries and has served fewer than its weight this
// round, starting a new round first if none has. Every input word gives exactly
// one result word on out_data, marked by a one-cycle out_valid strobe that the
// receiver must take when it appears. An enqueue, a rejected enqueue or a
// dequeue with nothing to serve reports in the cycle after it is taken and
// leaves busy low, so such words can follow each other in every cycle. A
// dequeue that serves an entry keeps busy high for one cycle while the entry
// is read from the queue memory and its service time is multiplied out.
// Configuration words on the cfg_ channel are always accepted and must only be
// sent while the block is idle. Reset empties all queues, clears the served
// counts and sets every weight and the unit time to one. No memory clearing
// pass is needed after reset.
module weighted_class_queue_scheduler (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  wcqs_pkg::in_word_t             in_data,
  output logic                           out_valid,
  output wcqs_pkg::out_word_t            out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [wcqs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [wcqs_pkg::CFG_DATA_W-1:0] cfg_data
);

  wcqs_pkg::state_t                state_r;
  wcqs_pkg::state_t                state_nxt;
  wcqs_pkg::weight_arr_t           weights_r;
  wcqs_pkg::weight_arr_t           weights_nxt;
  logic [wcqs_pkg::UNIT_W-1:0]     unit_r;
  logic [wcqs_pkg::UNIT_W-1:0]     unit_nxt;
  logic [wcqs_pkg::CLS_W-1:0]      pend_cls_r;
  logic [wcqs_pkg::CLS_W-1:0]      pend_cls_nxt;
  logic                            out_valid_r;
  logic                            out_valid_nxt;
  wcqs_pkg::out_word_t             out_r;
  wcqs_pkg::out_word_t             out_nxt;
  logic                            accept;
  wcqs_pkg::sched_t                dec;
  logic                            ram_we;
  logic [wcqs_pkg::ADDR_W-1:0]     ram_waddr;
  wcqs_pkg::entry_t                ram_wdata;
  logic [wcqs_pkg::ADDR_W-1:0]     ram_raddr;
  wcqs_pkg::entry_t                ram_rdata;
  logic [wcqs_pkg::TIME_W-1:0]     product;

  assign cfg_ready = 1'b1;
  assign busy      = (state_r == wcqs_pkg::ST_READ);
  assign accept    = start && !busy;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  wcqs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .in_word   (in_data),
    .weights   (weights_r),
    .dec       (dec),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr)
  );

  wcqs_ram #(
    .WIDTH ($bits(wcqs_pkg::entry_t)),
    .DEPTH (wcqs_pkg::MEM_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign product = {{(wcqs_pkg::TIME_W - wcqs_pkg::OPS_W){1'b0}}, ram_rdata.op_count} *
                   {{(wcqs_pkg::TIME_W - wcqs_pkg::UNIT_W){1'b0}}, unit_r};

  always_comb begin
    weights_nxt = weights_r;
    unit_nxt    = unit_r;
    if (cfg_valid && cfg_ready) begin
      if (cfg_index == wcqs_pkg::CFG_UNIT) begin
        unit_nxt = cfg_data;
      end else if (cfg_index <= wcqs_pkg::CFG_WEIGHT5) begin
        weights_nxt[cfg_index] = cfg_data[wcqs_pkg::WEIGHT_W-1:0];
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    pend_cls_nxt  = pend_cls_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    case (state_r)
      wcqs_pkg::ST_IDLE: begin
        if (accept) begin
          out_nxt               = '0;
          out_nxt.waiting_total = wcqs_pkg::WAIT_W'(dec.waiting_nxt);
          if (in_data.op == wcqs_pkg::OP_ENQ) begin
            out_valid_nxt  = 1'b1;
            out_nxt.status = dec.enq_ok ? wcqs_pkg::STAT_ENQ : wcqs_pkg::STAT_REJ;
          end else if (dec.deq_ok) begin
            state_nxt    = wcqs_pkg::ST_READ;
            pend_cls_nxt = wcqs_pkg::CLS_W'(dec.pick + 1'b1);
          end else begin
            out_valid_nxt  = 1'b1;
            out_nxt.status = wcqs_pkg::STAT_NONE;
          end
        end
      end
      wcqs_pkg::ST_READ: begin
        out_valid_nxt          = 1'b1;
        out_nxt.status         = wcqs_pkg::STAT_SERVED;
        out_nxt.served_account = ram_rdata.account;
        out_nxt.served_ops     = ram_rdata.op_count;
        out_nxt.served_class   = pend_cls_r;
        out_nxt.service_time   = product;
        out_nxt.waiting_total  = wcqs_pkg::WAIT_W'(dec.waiting);
        state_nxt              = wcqs_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = wcqs_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wcqs_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      unit_r      <= wcqs_pkg::UNIT_W'(1);
      for (int c = 0; c < wcqs_pkg::CLASS_COUNT; c++) begin
        weights_r[c] <= wcqs_pkg::WEIGHT_W'(1);
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      unit_r      <= unit_nxt;
      weights_r   <= weights_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_cls_r <= pend_cls_nxt;
    out_r      <= out_nxt;
  end

  // A served dequeue always reports at the end of its read cycle.
  a_read_reports: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == wcqs_pkg::ST_READ) |=> out_valid_r)
    else $error("read cycle did not produce a result word");

  // A dequeue that finds an entry must hold off the next input word.
  a_deq_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_data.op == wcqs_pkg::OP_DEQ) && dec.deq_ok) |=> busy)
    else $error("served dequeue did not raise busy");

  // A served word always names a class from one to five.
  a_served_class: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_r.status == wcqs_pkg::STAT_SERVED)) |->
      ((out_r.served_class != '0) &&
       (out_r.served_class <= wcqs_pkg::CLS_W'(wcqs_pkg::CLASS_COUNT))))
    else $error("served word has no valid class");

  // The waiting total can never exceed the capacity of all queues.
  a_total_cap: assert property (@(posedge clk) disable iff (!rst_n)
    dec.waiting <= wcqs_pkg::TOTAL_W'(wcqs_pkg::MEM_DEPTH))
    else $error("waiting total above queue capacity");

  // No word is reported while a served dequeue is still being read.
  a_no_early_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == wcqs_pkg::ST_READ) |-> !out_valid_r)
    else $error("result word during read cycle");

endmodule

### sv/wcqs_ram.sv
module wcqs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/wcqs_ctrl.sv
module wcqs_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         accept,
  input  wcqs_pkg::in_word_t           in_word,
  input  wcqs_pkg::weight_arr_t        weights,
  output wcqs_pkg::sched_t             dec,
  output logic                         ram_we,
  output logic [wcqs_pkg::ADDR_W-1:0]  ram_waddr,
  output wcqs_pkg::entry_t             ram_wdata,
  output logic [wcqs_pkg::ADDR_W-1:0]  ram_raddr
);

  logic [wcqs_pkg::PTR_W-1:0]    head_r   [wcqs_pkg::CLASS_COUNT];
  logic [wcqs_pkg::PTR_W-1:0]    tail_r   [wcqs_pkg::CLASS_COUNT];
  logic [wcqs_pkg::FILL_W-1:0]   fill_r   [wcqs_pkg::CLASS_COUNT];
  logic [wcqs_pkg::WEIGHT_W-1:0] served_r [wcqs_pkg::CLASS_COUNT];
  logic [wcqs_pkg::TOTAL_W-1:0]  total_r;
  logic [wcqs_pkg::TOTAL_W-1:0]  total_nxt;

  logic [wcqs_pkg::CLASS_COUNT-1:0] nonempty;
  logic [wcqs_pkg::CLASS_COUNT-1:0] elig;
  logic [wcqs_pkg::CLASS_COUNT-1:0] elig_clr;
  logic [wcqs_pkg::CLASS_COUNT-1:0] cand;
  logic                             need_clr;
  logic                             found;
  logic [wcqs_pkg::CLS_W-1:0]       pick;
  logic                             cls_ok;
  logic [wcqs_pkg::CLS_W-1:0]       widx;
  logic                             enq_ok;
  logic                             do_enq;
  logic                             do_deq;

  always_comb begin
    for (int c = 0; c < wcqs_pkg::CLASS_COUNT; c++) begin
      nonempty[c] = (fill_r[c] != '0);
      elig[c]     = (served_r[c] < weights[c]) && nonempty[c];
      elig_clr[c] = (weights[c] != '0) && nonempty[c];
    end
    need_clr = (elig == '0) && (nonempty != '0);
    cand     = need_clr ? elig_clr : elig;
    found    = (cand != '0);
    pick     = '0;
    for (int c = wcqs_pkg::CLASS_COUNT - 1; c >= 0; c--) begin
      if (cand[c]) begin
        pick = wcqs_pkg::CLS_W'(c);
      end
    end

    cls_ok = (in_word.class_id >= wcqs_pkg::CLS_W'(1)) &&
             (in_word.class_id <= wcqs_pkg::CLS_W'(wcqs_pkg::CLASS_COUNT));
    widx   = cls_ok ? wcqs_pkg::CLS_W'(in_word.class_id - 1'b1) : '0;
    enq_ok = cls_ok && (fill_r[widx] != wcqs_pkg::FILL_W'(wcqs_pkg::QUEUE_DEPTH));

    do_enq = accept && (in_word.op == wcqs_pkg::OP_ENQ) && enq_ok;
    do_deq = accept && (in_word.op == wcqs_pkg::OP_DEQ);

    total_nxt = total_r;
    if (do_enq) begin
      total_nxt = wcqs_pkg::TOTAL_W'(total_r + 1'b1);
    end else if (do_deq && found) begin
      total_nxt = wcqs_pkg::TOTAL_W'(total_r - 1'b1);
    end

    dec.enq_ok      = enq_ok;
    dec.deq_ok      = found;
    dec.pick        = pick;
    dec.waiting     = total_r;
    dec.waiting_nxt = total_nxt;

    ram_we            = do_enq;
    ram_waddr         = wcqs_pkg::slot_addr(widx, tail_r[widx]);
    ram_wdata.account = in_word.account;
    ram_wdata.op_count = in_word.op_count;
    ram_raddr         = wcqs_pkg::slot_addr(pick, head_r[pick]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < wcqs_pkg::CLASS_COUNT; c++) begin
        head_r[c]   <= '0;
        tail_r[c]   <= '0;
        fill_r[c]   <= '0;
        served_r[c] <= '0;
      end
      total_r <= '0;
    end else begin
      total_r <= total_nxt;
      if (do_enq) begin
        tail_r[widx] <= wcqs_pkg::ptr_inc(tail_r[widx]);
        fill_r[widx] <= wcqs_pkg::FILL_W'(fill_r[widx] + 1'b1);
      end
      if (do_deq) begin
        if (need_clr) begin
          for (int c = 0; c < wcqs_pkg::CLASS_COUNT; c++) begin
            served_r[c] <= '0;
          end
        end
        if (found) begin
          head_r[pick]   <= wcqs_pkg::ptr_inc(head_r[pick]);
          fill_r[pick]   <= wcqs_pkg::FILL_W'(fill_r[pick] - 1'b1);
          served_r[pick] <= need_clr ? wcqs_pkg::WEIGHT_W'(1)
                                     : wcqs_pkg::WEIGHT_W'(served_r[pick] + 1'b1);
        end
      end
    end
  end

endmodule

### test/wcqs_checker.sv
module wcqs_checker
  import wcqs_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic                   busy,
  input  in_word_t               in_data,
  input  logic                   out_valid,
  input  out_word_t              out_data,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     fail_count,
  output int                     pending
);
  timeunit 1ns;
  timeprecision 1ps;

  entry_t              slots [CLASS_COUNT][QUEUE_DEPTH];
  int                  head [CLASS_COUNT];
  int                  fill [CLASS_COUNT];
  logic [WEIGHT_W-1:0] served [CLASS_COUNT];
  logic [WEIGHT_W-1:0] weight [CLASS_COUNT];
  logic [UNIT_W-1:0]   unit_time;
  out_word_t           pending_results [$];
  int                  errors = 0;

  task automatic report(string field, logic [63:0] got, logic [63:0] want);
    errors++;
    $display("%0t ns: mismatch on %s: got 0x%0h, expected 0x%0h", $time, field, got, want);
  endtask

  function automatic int waiting_count();
    int sum;
    sum = 0;
    for (int c = 0; c < CLASS_COUNT; c++) begin
      sum += fill[c];
    end
    return sum;
  endfunction

  function automatic int pick_class();
    for (int c = 0; c < CLASS_COUNT; c++) begin
      if (served[c] < weight[c] && fill[c] > 0) begin
        return c;
      end
    end
    return -1;
  endfunction

  // Applies one request word to the scheduler state and returns its result word.
  function automatic out_word_t apply_request(in_word_t w);
    out_word_t r;
    entry_t    e;
    int        cls;
    int        c;
    r = '0;
    cls = int'(w.class_id);
    if (w.op == OP_ENQ) begin
      if (cls >= 1 && cls <= CLASS_COUNT && fill[cls-1] < QUEUE_DEPTH) begin
        e.account = w.account;
        e.op_count = w.op_count;
        slots[cls-1][(head[cls-1] + fill[cls-1]) % QUEUE_DEPTH] = e;
        fill[cls-1]++;
        r.status = STAT_ENQ;
      end else begin
        r.status = STAT_REJ;
      end
    end else begin
      c = pick_class();
      if (c < 0 && waiting_count() > 0) begin
        for (int k = 0; k < CLASS_COUNT; k++) begin
          served[k] = '0;
        end
        c = pick_class();
      end
      if (c >= 0) begin
        e = slots[c][head[c]];
        r.served_account = e.account;
        r.served_ops = e.op_count;
        r.served_class = CLS_W'(c + 1);
        r.service_time = TIME_W'(e.op_count) * TIME_W'(unit_time);
        head[c] = (head[c] + 1) % QUEUE_DEPTH;
        fill[c]--;
        served[c] = served[c] + 1'b1;
        r.status = STAT_SERVED;
      end else begin
        r.status = STAT_NONE;
      end
    end
    r.waiting_total = WAIT_W'(waiting_count());
    return r;
  endfunction

  always @(posedge clk) begin
    out_word_t want;
    if (!rst_n) begin
      for (int c = 0; c < CLASS_COUNT; c++) begin
        head[c] = 0;
        fill[c] = 0;
        served[c] = '0;
        weight[c] = WEIGHT_W'(1);
      end
      unit_time = UNIT_W'(1);
      pending_results.delete();
    end else begin
      if (out_valid !== 1'b0) begin
        if (pending_results.size() == 0) begin
          report("result word with nothing expected", 64'(out_data.status), '0);
        end else begin
          want = pending_results.pop_front();
          if (out_data.status !== want.status)
            report("status", 64'(out_data.status), 64'(want.status));
          if (out_data.served_account !== want.served_account)
            report("served_account", 64'(out_data.served_account), 64'(want.served_account));
          if (out_data.served_ops !== want.served_ops)
            report("served_ops", 64'(out_data.served_ops), 64'(want.served_ops));
          if (out_data.served_class !== want.served_class)
            report("served_class", 64'(out_data.served_class), 64'(want.served_class));
          if (out_data.service_time !== want.service_time)
            report("service_time", 64'(out_data.service_time), 64'(want.service_time));
          if (out_data.waiting_total !== want.waiting_total)
            report("waiting_total", 64'(out_data.waiting_total), 64'(want.waiting_total));
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index <= CFG_WEIGHT5) begin
          weight[cfg_index] = cfg_data[WEIGHT_W-1:0];
        end else if (cfg_index == CFG_UNIT) begin
          unit_time = cfg_data[UNIT_W-1:0];
        end
      end
      if (start && !busy) begin
        pending_results.push_back(apply_request(in_data));
      end
    end
    fail_count <= errors;
    pending <= pending_results.size();
  end

endmodule

### test/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import wcqs_pkg::*;

  typedef enum int {
    MIX_FILL,
    MIX_DRAIN,
    MIX_EVEN
  } mix_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  in_word_t              in_data = '0;
  logic                  out_valid;
  out_word_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int                    fail_count;
  int                    pending;

  always #1 clk = ~clk;

  weighted_class_queue_scheduler dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  wcqs_checker u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  function automatic in_word_t enq_word(int cls, logic [ACCOUNT_W-1:0] acct,
                                        logic [OPS_W-1:0] ops);
    in_word_t w;
    w.op = OP_ENQ;
    w.class_id = CLS_W'(cls);
    w.account = acct;
    w.op_count = ops;
    return w;
  endfunction

  function automatic in_word_t deq_word();
    in_word_t w;
    w.op = OP_DEQ;
    w.class_id = CLS_W'($urandom_range(0, 7));
    w.account = ACCOUNT_W'($urandom);
    w.op_count = OPS_W'($urandom);
    return w;
  endfunction

  // Fill traffic is mostly enqueues aimed at one class so that its queue runs full.
  function automatic in_word_t make_item(mix_t mix, int focus);
    in_word_t w;
    int       deq_pct;
    int       r;
    w.account = ACCOUNT_W'($urandom);
    w.op_count = OPS_W'($urandom);
    w.class_id = CLS_W'($urandom_range(1, CLASS_COUNT));
    deq_pct = (mix == MIX_FILL) ? 5 : (mix == MIX_DRAIN) ? 90 : 50;
    w.op = ($urandom_range(0, 99) < deq_pct) ? OP_DEQ : OP_ENQ;
    r = $urandom_range(0, 99);
    if (mix == MIX_FILL && r < 80) begin
      w.class_id = CLS_W'(focus);
    end else if (r >= 94) begin
      w.class_id = CLS_W'($urandom_range(0, 7));
    end
    return w;
  endfunction

  task automatic send_word(in_word_t w, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      in_data <= deq_word();
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (busy);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Writes go out only once every outstanding word has come back.
  task automatic program_regs(weight_arr_t wts, logic [UNIT_W-1:0] unit);
    wait_drained();
    for (int c = 0; c < CLASS_COUNT; c++) begin
      write_reg(CFG_IDX_W'(c), {8'($urandom), wts[c]});
    end
    write_reg(CFG_UNIT, unit);
    write_reg(CFG_IDX_W'(CFG_UNIT + 1), CFG_DATA_W'($urandom));
    write_reg(CFG_IDX_W'(CFG_UNIT + 2), CFG_DATA_W'($urandom));
    cfg_valid <= 1'b0;
  endtask

  initial begin
    #1_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    weight_arr_t       wts;
    logic [UNIT_W-1:0] unit;
    mix_t              mix;
    int                gap;
    bit                burst;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    send_word(deq_word(), $urandom_range(0, 7));
    send_word(enq_word(0, ACCOUNT_W'($urandom), OPS_W'($urandom)), $urandom_range(0, 7));
    send_word(enq_word(6, ACCOUNT_W'($urandom), OPS_W'($urandom)), $urandom_range(0, 7));
    send_word(enq_word(7, ACCOUNT_W'($urandom), OPS_W'($urandom)), $urandom_range(0, 7));
    send_word(enq_word(1, '1, '1), $urandom_range(0, 7));
    send_word(enq_word(2, '0, '0), $urandom_range(0, 7));
    for (int c = 3; c <= CLASS_COUNT; c++) begin
      send_word(enq_word(c, ACCOUNT_W'($urandom), OPS_W'($urandom)), 0);
    end
    send_word(enq_word(1, ACCOUNT_W'($urandom), OPS_W'($urandom)), $urandom_range(0, 7));
    for (int n = 0; n < 7; n++) begin
      send_word(deq_word(), $urandom_range(0, 7));
    end

    program_regs('0, '1);
    send_word(enq_word(4, ACCOUNT_W'($urandom), '1), $urandom_range(0, 7));
    send_word(deq_word(), $urandom_range(0, 7));
    program_regs('1, '1);
    send_word(deq_word(), $urandom_range(0, 7));
    send_word(deq_word(), 0);

    for (int p = 0; p < 12; p++) begin
      for (int c = 0; c < CLASS_COUNT; c++) begin
        case ($urandom_range(0, 3))
          0: wts[c] = '0;
          1: wts[c] = '1;
          2: wts[c] = WEIGHT_W'($urandom_range(1, 3));
          default: wts[c] = WEIGHT_W'($urandom);
        endcase
      end
      case ($urandom_range(0, 3))
        0: unit = '0;
        1: unit = '1;
        2: unit = UNIT_W'($urandom_range(1, 16));
        default: unit = UNIT_W'($urandom);
      endcase
      if (p == 1) begin
        unit = '0;
      end
      program_regs(wts, unit);
      mix = (p < 5) ? MIX_FILL : (p == 5 || p == 10) ? MIX_EVEN : MIX_DRAIN;
      burst = (p % 3 == 2);
      for (int n = 0; n < 60; n++) begin
        gap = burst ? 0 : $urandom_range(0, 7);
        send_word(make_item(mix, (p % CLASS_COUNT) + 1), gap);
      end
    end

    wait_drained();
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
